>>> hdl/mdftm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdftm_pkg: shared types and constants for the feedback timeout monitor
// Holds the transfer structs, command and result codes, sizes and the
// per-device limit ROMs.
// ----------------------------------------------------------------------------
package mdftm_pkg;

    localparam int NUM_DEVICES = 21;
    localparam int TIME_BITS   = 32;
    localparam int MASK_BITS   = 21;
    localparam int IDX_BITS    = 5;
    localparam int LIM_BITS    = 16;

    // Input item kinds
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_FEEDBACK = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;

    // Result kinds
    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_ANSWER = 1'b1;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [4:0]  device;
        logic [31:0] now;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [4:0] device_id;
        logic       offline;
        logic       last;
    } out_item_t;

    // Write request into the stamp store
    typedef struct packed {
        logic                 clear;
        logic                 en;
        logic [IDX_BITS-1:0]  idx;
        logic [TIME_BITS-1:0] data;
    } stamp_wr_t;

    // Offline limit: time since feedback above this marks the device lost
    function automatic logic [LIM_BITS-1:0] lim_offline(input logic [IDX_BITS-1:0] idx);
        logic [LIM_BITS-1:0] v;
        unique case (idx)
            5'd0:                    v = 16'd30;
            5'd1, 5'd2, 5'd3, 5'd4:  v = 16'd10;
            5'd5, 5'd6, 5'd7, 5'd8:  v = 16'd2;
            5'd9:                    v = 16'd10;
            5'd10, 5'd11, 5'd12:     v = 16'd100;
            5'd13, 5'd14, 5'd15:     v = 16'd2;
            5'd16:                   v = 16'd5;
            5'd17:                   v = 16'd40;
            5'd18:                   v = 16'd100;
            5'd19:                   v = 16'd10;
            5'd20:                   v = 16'd100;
            default:                 v = '0;
        endcase
        return v;
    endfunction

    // Online hold: time since start needed before a device may go online
    function automatic logic [LIM_BITS-1:0] lim_hold(input logic [IDX_BITS-1:0] idx);
        logic [LIM_BITS-1:0] v;
        unique case (idx)
            5'd0, 5'd1, 5'd2, 5'd3, 5'd4: v = 16'd0;
            5'd5, 5'd6, 5'd7, 5'd8:       v = 16'd3;
            5'd9:                         v = 16'd10;
            5'd10, 5'd11, 5'd12:          v = 16'd100;
            5'd13, 5'd14, 5'd15:          v = 16'd3;
            5'd16:                        v = 16'd5;
            5'd17:                        v = 16'd200;
            5'd18:                        v = 16'd100;
            5'd19:                        v = 16'd10;
            5'd20:                        v = 16'd100;
            default:                      v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/mdftm_sub_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdftm_sub_cmp: shared elapsed-time unit
// Takes a wrapping difference of two time stamps and compares it with a
// limit; the sequencer reuses it for every device of a scan.
// ----------------------------------------------------------------------------
module mdftm_sub_cmp (
    input  logic [mdftm_pkg::TIME_BITS-1:0] a,
    input  logic [mdftm_pkg::TIME_BITS-1:0] b,
    input  logic [mdftm_pkg::LIM_BITS-1:0]  lim,
    output logic [mdftm_pkg::TIME_BITS-1:0] diff,
    output logic                            gt
);

    // Subtract modulo 2^TIME_BITS, then compare against the widened limit
    assign diff = a - b;
    assign gt   = diff > mdftm_pkg::TIME_BITS'(lim);

endmodule

>>> hdl/mdftm_stamp_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdftm_stamp_store: per-device feedback time stamps
// One write port, one read port. An entry not written since the last clear
// reads as the start stamp.
// ----------------------------------------------------------------------------
module mdftm_stamp_store (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mdftm_pkg::stamp_wr_t               wr,
    input  logic [mdftm_pkg::IDX_BITS-1:0]     rd_idx,
    input  logic [mdftm_pkg::TIME_BITS-1:0]    dflt,
    output logic [mdftm_pkg::TIME_BITS-1:0]    rd_data
);

    logic [mdftm_pkg::TIME_BITS-1:0]   stamp_reg [mdftm_pkg::NUM_DEVICES];
    logic [mdftm_pkg::NUM_DEVICES-1:0] written_reg;
    logic [mdftm_pkg::NUM_DEVICES-1:0] written_next;

    // Clear all valid bits first, then mark the entry being written
    always_comb
    begin
        written_next = wr.clear ? '0 : written_reg;
        if (wr.en)
        begin
            written_next[wr.idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
        end
        else
        begin
            written_reg <= written_next;
        end
    end

    // Hold stamp payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            stamp_reg[wr.idx] <= wr.data;
        end
    end

    assign rd_data = written_reg[rd_idx] ? stamp_reg[rd_idx] : dflt;

endmodule

>>> hdl/multi_device_feedback_timeout_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_device_feedback_timeout_monitor: watchdog over a table of devices
// Tracks last feedback time and offline state per device; tick scans emit
// flag change events, queries return a device's flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries tick, feedback and query
//   items. Output channel out_valid/out_ready/out_data carries events and
//   query answers; the final result of an item has last set.
//   cfg_wr_en/cfg_wr_data write the device enable mask at any idle time.
// Timing:
//   Feedback leaves in_ready high. A query holds in_ready low in ST_QUERY
//   until its answer is loaded into the output register, which waits for
//   the register to be free. A tick holds in_ready low through ST_START for
//   the time since start, ST_SCAN with one device per cycle through the
//   single subtract/compare unit unless an event stalls the scan, and
//   ST_FLUSH for the final event. in_ready is high only between items.
// Reset:
//   The table is empty after reset; the first item of any kind loads every stamp
//   and the start time with its time and marks all devices offline but a fed-back one.
// Back-pressure:
//   A held result waits in the output register; a scan with a further event
//   stalls on its device until the register drains.
// ----------------------------------------------------------------------------
module multi_device_feedback_timeout_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mdftm_pkg::in_item_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mdftm_pkg::out_item_t                out_data,
    input  logic                                cfg_wr_en,
    input  logic [mdftm_pkg::MASK_BITS-1:0]     cfg_wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_FLUSH,
        ST_QUERY
    } state_t;

    localparam logic [mdftm_pkg::IDX_BITS-1:0] LAST_IDX =
        mdftm_pkg::IDX_BITS'(mdftm_pkg::NUM_DEVICES - 1);
    localparam logic [mdftm_pkg::IDX_BITS-1:0] DEV_COUNT =
        mdftm_pkg::IDX_BITS'(mdftm_pkg::NUM_DEVICES);

    state_t                              state_reg;
    logic                                init_reg;
    logic [mdftm_pkg::MASK_BITS-1:0]     mask_reg;
    logic [mdftm_pkg::NUM_DEVICES-1:0]   off_reg;
    logic [mdftm_pkg::NUM_DEVICES-1:0]   rep_reg;
    logic [mdftm_pkg::TIME_BITS-1:0]     start_reg;
    logic [mdftm_pkg::TIME_BITS-1:0]     now_reg;
    logic [mdftm_pkg::TIME_BITS-1:0]     elapsed_reg;
    logic [mdftm_pkg::IDX_BITS-1:0]      idx_reg;
    logic [mdftm_pkg::IDX_BITS-1:0]      dev_reg;
    logic                                pend_valid_reg;
    logic [mdftm_pkg::IDX_BITS-1:0]      pend_dev_reg;
    logic                                pend_off_reg;
    logic                                out_valid_reg;
    mdftm_pkg::out_item_t                out_reg;

    logic                                in_xfer;
    logic                                slot_free;
    logic                                dev_in_range;
    logic                                in_dev_ok;
    mdftm_pkg::stamp_wr_t                stamp_wr;
    logic [mdftm_pkg::TIME_BITS-1:0]     stamp_rd;
    logic [mdftm_pkg::TIME_BITS-1:0]     unit_b;
    logic [mdftm_pkg::TIME_BITS-1:0]     unit_diff;
    logic                                unit_gt;
    logic                                hold_ok;
    logic                                new_off;
    logic                                change;
    logic                                scan_push;
    logic                                scan_stall;
    logic                                out_push;
    logic [mdftm_pkg::NUM_DEVICES-1:0]   off_fb;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign in_dev_ok    = in_data.device < DEV_COUNT;
    assign dev_in_range = dev_reg < DEV_COUNT;

    // Stamp writes: clear on the first item, store time on in-range feedback
    always_comb
    begin
        stamp_wr.clear = in_xfer && !init_reg;
        stamp_wr.en    = in_xfer && (in_data.cmd == mdftm_pkg::CMD_FEEDBACK) && in_dev_ok;
        stamp_wr.idx   = in_data.device;
        stamp_wr.data  = in_data.now;
    end

    mdftm_stamp_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (stamp_wr),
        .rd_idx  (idx_reg),
        .dflt    (start_reg),
        .rd_data (stamp_rd)
    );

    // Share the unit: start elapsed time first, then one stamp per cycle unless the scan stalls
    assign unit_b = (state_reg == ST_START) ? start_reg : stamp_rd;

    mdftm_sub_cmp u_unit (
        .a    (now_reg),
        .b    (unit_b),
        .lim  (mdftm_pkg::lim_offline(idx_reg)),
        .diff (unit_diff),
        .gt   (unit_gt)
    );

    // Decide the scanned device's new flag and whether it is reported
    always_comb
    begin
        hold_ok    = elapsed_reg >= mdftm_pkg::TIME_BITS'(mdftm_pkg::lim_hold(idx_reg));
        new_off    = unit_gt ? 1'b1 : (hold_ok ? 1'b0 : off_reg[idx_reg]);
        change     = mask_reg[idx_reg] && (rep_reg[idx_reg] != new_off);
        scan_push  = change && pend_valid_reg && slot_free;
        scan_stall = change && pend_valid_reg && !slot_free;
    end

    // Load a new result into the output register this cycle
    assign out_push = ((state_reg == ST_SCAN) && scan_push) ||
                      ((state_reg == ST_FLUSH) && pend_valid_reg && slot_free) ||
                      ((state_reg == ST_QUERY) && slot_free);

    // Flags after a feedback: all offline on the first item, then clear one
    always_comb
    begin
        off_fb = init_reg ? off_reg : '1;
        if (in_dev_ok)
        begin
            off_fb[in_data.device] = 1'b0;
        end
    end

    // Sequencer, table flags and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            init_reg       <= 1'b0;
            mask_reg       <= '1;
            off_reg        <= '1;
            rep_reg        <= '1;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mask_reg <= cfg_wr_data;
            end

            // Drop the output once taken unless a new result replaces it
            if (out_ready && !out_push)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        now_reg  <= in_data.now;
                        dev_reg  <= in_data.device;
                        idx_reg  <= '0;
                        init_reg <= 1'b1;
                        if (!init_reg)
                        begin
                            start_reg <= in_data.now;
                            rep_reg   <= '1;
                        end
                        if ((in_data.cmd == mdftm_pkg::CMD_FEEDBACK) && in_dev_ok)
                        begin
                            off_reg <= off_fb;
                        end
                        else if (!init_reg)
                        begin
                            off_reg <= '1;
                        end
                        if (in_data.cmd == mdftm_pkg::CMD_TICK)
                        begin
                            state_reg <= ST_START;
                        end
                        else if (in_data.cmd == mdftm_pkg::CMD_QUERY)
                        begin
                            state_reg <= ST_QUERY;
                        end
                    end
                end

                ST_START:
                begin
                    elapsed_reg    <= unit_diff;
                    pend_valid_reg <= 1'b0;
                    state_reg      <= ST_SCAN;
                end

                ST_SCAN:
                begin
                    if (!scan_stall)
                    begin
                        if (mask_reg[idx_reg])
                        begin
                            off_reg[idx_reg] <= new_off;
                        end
                        if (change)
                        begin
                            rep_reg[idx_reg] <= new_off;
                            pend_valid_reg   <= 1'b1;
                            pend_dev_reg     <= idx_reg;
                            pend_off_reg     <= new_off;
                        end
                        if (scan_push)
                        begin
                            out_valid_reg     <= 1'b1;
                            out_reg.kind      <= mdftm_pkg::KIND_EVENT;
                            out_reg.device_id <= pend_dev_reg;
                            out_reg.offline   <= pend_off_reg;
                            out_reg.last      <= 1'b0;
                        end
                        if (idx_reg == LAST_IDX)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end
                end

                ST_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (slot_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_reg.kind      <= mdftm_pkg::KIND_EVENT;
                        out_reg.device_id <= pend_dev_reg;
                        out_reg.offline   <= pend_off_reg;
                        out_reg.last      <= 1'b1;
                        pend_valid_reg    <= 1'b0;
                        state_reg         <= ST_IDLE;
                    end
                end

                ST_QUERY:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg     <= 1'b1;
                        out_reg.kind      <= mdftm_pkg::KIND_ANSWER;
                        out_reg.device_id <= dev_reg;
                        out_reg.offline   <= dev_in_range ? off_reg[dev_reg] : 1'b0;
                        out_reg.last      <= 1'b1;
                        state_reg         <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
